@@ rtl/u8o_pkg.sv @@
// ----------------------------------------------------------------------------
// u8o_pkg
// Shared types, codes and helpers for the utf-8 position to byte offset
// resolver.
// ----------------------------------------------------------------------------
package u8o_pkg;

  // default depth of the wanted position queue
  localparam int QUEUE_DEPTH_DEF = 256;

  // depth of the command queue between front and back (power of two)
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_IDX_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // input action codes
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_BYTE   = 2'd2;
  localparam logic [1:0] ACT_FINISH = 2'd3;

  // result kind codes
  localparam logic KIND_PAIR   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // lead byte masks and patterns
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_PAT   = 8'hC0;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_PAT   = 8'hE0;
  localparam logic [7:0] LEAD4_MASK  = 8'hF8;
  localparam logic [7:0] LEAD4_PAT   = 8'hF0;

  // classified command handed from front to back
  typedef struct packed {
    logic [1:0]  op;
    logic        pos_zero;
    logic [31:0] pos;
    logic [1:0]  cont_cnt;
  } cmd_t;

  // command queue read side
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmdq_rd_t;

  // one result item
  typedef struct packed {
    logic        kind;
    logic [31:0] char_position;
    logic [31:0] byte_offset;
    logic        all_resolved;
    logic        overflow;
    logic        last;
  } res_t;

  // number of continuation bytes that follow a lead byte
  function automatic logic [1:0] cont_bytes(input logic [7:0] b);
    logic [1:0] n;
    if (b < ASCII_LIMIT) begin
      n = 2'd0;
    end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
      n = 2'd1;
    end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
      n = 2'd2;
    end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
      n = 2'd3;
    end else begin
      n = 2'd0;
    end
    return n;
  endfunction

  // saturating 32-bit increment
  function automatic logic [31:0] sat_inc(input logic [31:0] x);
    return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
  endfunction

endpackage

@@ rtl/u8o_if.sv @@
// ----------------------------------------------------------------------------
// u8o_in_if / u8o_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface u8o_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] wanted_position;
  logic [7:0]  text_byte;

  modport source (output valid, action, wanted_position, text_byte, input ready);
  modport sink   (input valid, action, wanted_position, text_byte, output ready);
endinterface

interface u8o_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] char_position;
  logic [31:0] byte_offset;
  logic        all_resolved;
  logic        overflow;
  logic        last;

  modport source (output valid, kind, char_position, byte_offset, all_resolved,
                  overflow, last, input ready);
  modport sink   (input valid, kind, char_position, byte_offset, all_resolved,
                  overflow, last, output ready);
endinterface

@@ rtl/u8o_front.sv @@
// ----------------------------------------------------------------------------
// u8o_front
// Accepts input items and classifies them into commands for the back end.
// ----------------------------------------------------------------------------
module u8o_front (
  u8o_in_if.sink        in_ch,
  input  logic          q_full_i,
  output logic          push_o,
  output u8o_pkg::cmd_t cmd_o
);

  // accept while the command queue has room
  assign in_ch.ready = !q_full_i;
  assign push_o      = in_ch.valid && !q_full_i;

  // classify: zero load and lead byte width are decided up front
  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = in_ch.action;
    cmd_o.pos      = in_ch.wanted_position;
    cmd_o.pos_zero = (in_ch.wanted_position == 32'd0);
    cmd_o.cont_cnt = u8o_pkg::cont_bytes(in_ch.text_byte);
  end

endmodule

@@ rtl/u8o_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// u8o_cmd_fifo
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module u8o_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  u8o_pkg::cmd_t     cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output u8o_pkg::cmdq_rd_t rd_o
);

  u8o_pkg::cmd_t                      slot_r [u8o_pkg::CMDQ_DEPTH];
  logic [u8o_pkg::CMDQ_IDX_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [u8o_pkg::CMDQ_IDX_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [u8o_pkg::CMDQ_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                               do_push, do_pop;

  assign full_o   = (cnt_r == u8o_pkg::CMDQ_CNT_W'(u8o_pkg::CMDQ_DEPTH));
  assign rd_o.valid = (cnt_r != '0);
  assign rd_o.cmd   = slot_r[rd_ptr_r];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && rd_o.valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // command storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= cmd_i;
    end
  end

endmodule

@@ rtl/u8o_back.sv @@
// ----------------------------------------------------------------------------
// u8o_back
// Executes commands: wanted position queue, character and byte counters,
// head compare and the result register.
// ----------------------------------------------------------------------------
module u8o_back #(
  parameter int QUEUE_DEPTH = u8o_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  u8o_pkg::cmdq_rd_t rd_i,
  output logic              pop_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output u8o_pkg::res_t     res_o
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // wrap-around increment of a queue index
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] x);
    return (x == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : x + 1'b1;
  endfunction

  logic [31:0]      mem [QUEUE_DEPTH];
  logic [31:0]      rdata_r;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      head_val_r, head_val_nxt;
  logic [31:0]      cc_r, cc_nxt;
  logic [31:0]      bc_r, bc_nxt;
  logic [1:0]       pend_r, pend_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r, out_valid_nxt;
  u8o_pkg::res_t    res_r, res_nxt;

  logic             go;
  logic             res_gen;
  logic             do_complete;
  logic             complete_last;
  logic             pop_q;
  logic             mem_we;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;
  logic [CNT_W:0]   tail_sum;
  logic [31:0]      cc_inc;
  logic             q_full;
  logic             is_clear;

  u8o_pkg::cmd_t    cmd;

  assign cmd      = rd_i.cmd;
  assign go       = rd_i.valid && (!out_valid_r || out_ready_i);
  assign q_full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign cc_inc   = u8o_pkg::sat_inc(cc_r);
  assign is_clear = go && (cmd.op == u8o_pkg::ACT_CLEAR);

  // finish with a pending character holds its command for a second pass
  assign pop_o = go && !((cmd.op == u8o_pkg::ACT_FINISH) && (pend_r != 2'd0));

  // tail index = head + count, wrapped
  always_comb begin
    tail_sum = (CNT_W+1)'(head_r) + (CNT_W+1)'(count_r);
    if (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    waddr = tail_sum[IDX_W-1:0];
  end

  // command execution
  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    head_val_nxt  = head_val_r;
    cc_nxt        = cc_r;
    bc_nxt        = bc_r;
    pend_nxt      = pend_r;
    ovf_nxt       = ovf_r;
    res_gen       = 1'b0;
    res_nxt       = res_r;
    do_complete   = 1'b0;
    complete_last = 1'b1;
    pop_q         = 1'b0;
    mem_we        = 1'b0;

    if (go) begin
      case (cmd.op)
        u8o_pkg::ACT_CLEAR: begin
          head_nxt  = '0;
          count_nxt = '0;
          cc_nxt    = '0;
          bc_nxt    = '0;
          pend_nxt  = '0;
          ovf_nxt   = 1'b0;
        end
        u8o_pkg::ACT_LOAD: begin
          if (cmd.pos_zero) begin
            res_gen               = 1'b1;
            res_nxt.kind          = u8o_pkg::KIND_PAIR;
            res_nxt.char_position = '0;
            res_nxt.byte_offset   = '0;
            res_nxt.all_resolved  = 1'b0;
            res_nxt.overflow      = ovf_r;
            res_nxt.last          = 1'b1;
          end else if (q_full) begin
            ovf_nxt = 1'b1;
          end else begin
            mem_we    = 1'b1;
            count_nxt = count_r + 1'b1;
            if (count_r == '0) begin
              head_val_nxt = cmd.pos;
            end
          end
        end
        u8o_pkg::ACT_BYTE: begin
          bc_nxt = u8o_pkg::sat_inc(bc_r);
          if (pend_r != 2'd0) begin
            pend_nxt    = pend_r - 2'd1;
            do_complete = (pend_r == 2'd1);
          end else if (cmd.cont_cnt == 2'd0) begin
            do_complete = 1'b1;
          end else begin
            pend_nxt = cmd.cont_cnt;
          end
        end
        u8o_pkg::ACT_FINISH: begin
          if (pend_r != 2'd0) begin
            pend_nxt      = '0;
            do_complete   = 1'b1;
            complete_last = 1'b0;
          end else begin
            res_gen               = 1'b1;
            res_nxt.kind          = u8o_pkg::KIND_STATUS;
            res_nxt.char_position = cc_r;
            res_nxt.byte_offset   = bc_r;
            res_nxt.all_resolved  = (count_r == '0);
            res_nxt.overflow      = ovf_r;
            res_nxt.last          = 1'b1;
          end
        end
        default: begin
          res_gen = 1'b0;
        end
      endcase

      // character completed: compare against the queue head
      if (do_complete) begin
        cc_nxt = cc_inc;
        if ((count_r != '0) && (head_val_r == cc_inc)) begin
          res_gen               = 1'b1;
          res_nxt.kind          = u8o_pkg::KIND_PAIR;
          res_nxt.char_position = cc_inc;
          res_nxt.byte_offset   = bc_nxt;
          res_nxt.all_resolved  = 1'b0;
          res_nxt.overflow      = ovf_r;
          res_nxt.last          = complete_last;
          pop_q                 = 1'b1;
        end
      end

      // pop the head; the entry behind it was read last cycle
      if (pop_q) begin
        head_nxt     = idx_inc(head_r);
        count_nxt    = count_r - 1'b1;
        head_val_nxt = rdata_r;
      end
    end
  end

  // prefetch the entry behind the next head
  assign raddr = idx_inc(head_nxt);

  // output register
  always_comb begin
    if (res_gen) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready_i) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid_o = out_valid_r;
  assign res_o       = res_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      cc_r        <= '0;
      bc_r        <= '0;
      pend_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      cc_r        <= cc_nxt;
      bc_r        <= bc_nxt;
      pend_r      <= pend_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    head_val_r <= head_val_nxt;
    res_r      <= res_nxt;
  end

  // wanted position memory, read data registered, write passes through
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= cmd.pos;
    end
    if (mem_we && (waddr == raddr)) begin
      rdata_r <= cmd.pos;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  // queue never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("wanted queue count above depth");

  // a resolved pair pops exactly one entry
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    pop_q |=> count_r == $past(count_r) - 1'b1)
    else $error("head pop did not decrement count");

  // overflow flag is sticky until clear
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r && !is_clear |=> ovf_r)
    else $error("overflow flag dropped without clear");

  // finish always completes a pending character
  a_finish_flush: assert property (@(posedge clk) disable iff (!rst_n)
    go && (cmd.op == u8o_pkg::ACT_FINISH) |=> pend_r == 2'd0)
    else $error("pending character survived finish");

endmodule

@@ rtl/utf8_char_to_byte_offset_resolver_top.sv @@
// ----------------------------------------------------------------------------
// utf8_char_to_byte_offset_resolver_top
// Resolves utf-8 character positions into byte offsets over a byte stream.
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one action per transfer: clear, load a wanted position
//   (ascending), one text byte, or finish. out_ch carries resolved
//   position/byte pairs and the finish status; last marks the final result
//   of an input item.
//   a load of position zero answers (0, 0) at once. a load into a full
//   wanted queue is dropped and sets the sticky overflow flag.
// throughput:
//   an item passes the command queue, then the back end, which registers
//   its result. the back end executes one item per cycle while the result
//   register is free or taken; a finish that closes a truncated character
//   is held for a second pass. a resolved head is replaced from memory read
//   one entry ahead of the head, so consecutive matches run at one per cycle.
// reset and stall:
//   reset empties the wanted queue and command queue and zeroes counters
//   and flags. when out_ch is stalled the result register holds; the
//   command queue absorbs up to four more items before in_ch.ready drops.
// ----------------------------------------------------------------------------
module utf8_char_to_byte_offset_resolver_top #(
  parameter int QUEUE_DEPTH = u8o_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  u8o_in_if.sink     in_ch,
  u8o_out_if.source  out_ch
);

  logic              push;
  logic              q_full;
  logic              pop;
  u8o_pkg::cmd_t     cmd;
  u8o_pkg::cmdq_rd_t rd;
  u8o_pkg::res_t     res;

  // classify incoming items
  u8o_front u_front (
    .in_ch    (in_ch),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (cmd)
  );

  // command queue between front and back
  u8o_cmd_fifo u_cmdq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .cmd_i  (cmd),
    .full_o (q_full),
    .pop_i  (pop),
    .rd_o   (rd)
  );

  // execution and result register
  u8o_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_i        (rd),
    .pop_o       (pop),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .res_o       (res)
  );

  // result channel payload
  assign out_ch.kind          = res.kind;
  assign out_ch.char_position = res.char_position;
  assign out_ch.byte_offset   = res.byte_offset;
  assign out_ch.all_resolved  = res.all_resolved;
  assign out_ch.overflow      = res.overflow;
  assign out_ch.last          = res.last;

endmodule

@@ test/utf8_char_to_byte_offset_resolver_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_char_to_byte_offset_resolver_top_tb
// Streams wanted positions, utf-8 text bytes, finishes and clears into the
// resolver through a bursty driver. A stalling monitor checks every result
// against an in-bench predictor of the queue, counters and overflow flag.
// ----------------------------------------------------------------------------
module utf8_char_to_byte_offset_resolver_top_tb;

  localparam int WANTED_DEPTH = u8o_pkg::QUEUE_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1300;
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct {
    logic [1:0]  action;
    logic [31:0] wanted_position;
    logic [7:0]  text_byte;
  } stim_item_t;

  typedef enum logic [1:0] {
    RX_FREE, RX_THREE_QUARTERS, RX_COIN, RX_LONG_STALL
  } rx_mode_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // testbench-side drivers of the block inputs, known from time zero
  logic        drv_valid    = 1'b0;
  logic [1:0]  drv_action   = u8o_pkg::ACT_CLEAR;
  logic [31:0] drv_position = '0;
  logic [7:0]  drv_byte     = '0;
  logic        take_ready   = 1'b0;

  u8o_in_if  in_ch ();
  u8o_out_if out_ch ();

  assign in_ch.valid           = drv_valid;
  assign in_ch.action          = drv_action;
  assign in_ch.wanted_position = drv_position;
  assign in_ch.text_byte       = drv_byte;
  assign out_ch.ready          = take_ready;

  utf8_char_to_byte_offset_resolver_top #(
    .QUEUE_DEPTH(WANTED_DEPTH)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial forever #1 clk = ~clk;

  // stimulus and expected results
  stim_item_t      stimulus_items[$];
  u8o_pkg::res_t   pending_results[$];
  int unsigned items_total    = 0;
  int unsigned items_accepted = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;

  // predictor state
  logic [31:0] wanted_fifo[$];
  logic [31:0] chars_seen    = '0;
  logic [31:0] bytes_seen    = '0;
  logic [1:0]  conts_left    = '0;
  logic        overflow_seen = 1'b0;

  function automatic u8o_pkg::res_t make_result(logic kind, logic [31:0] pos,
                                                logic [31:0] off, logic all,
                                                logic ovf, logic fin);
    u8o_pkg::res_t r;
    r.kind          = kind;
    r.char_position = pos;
    r.byte_offset   = off;
    r.all_resolved  = all;
    r.overflow      = ovf;
    r.last          = fin;
    return r;
  endfunction

  // append one expected result
  function void expect_result(u8o_pkg::res_t r);
    pending_results = {pending_results, r};
  endfunction

  // continuation bytes implied by a lead byte; bad leads stand alone
  function automatic logic [1:0] trailing_count(logic [7:0] b);
    casez (b)
      8'b0???????: return 2'd0;
      8'b110?????: return 2'd1;
      8'b1110????: return 2'd2;
      8'b11110???: return 2'd3;
      default:     return 2'd0;
    endcase
  endfunction

  // one character done: bump count, pop the head if it matches
  function bit close_char(output u8o_pkg::res_t pair);
    if (chars_seen != 32'hFFFF_FFFF) chars_seen++;
    pair = '0;
    if (wanted_fifo.size() != 0 && wanted_fifo[0] == chars_seen) begin
      pair = make_result(u8o_pkg::KIND_PAIR, chars_seen, bytes_seen, 1'b0,
                         overflow_seen, 1'b0);
      void'(wanted_fifo.pop_front());
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // expected results of one accepted transfer
  function void resolve_item(logic [1:0] action, logic [31:0] pos, logic [7:0] b);
    u8o_pkg::res_t pair;
    bit            got_pair;
    got_pair = 1'b0;
    case (action)
      u8o_pkg::ACT_CLEAR: begin
        wanted_fifo.delete();
        chars_seen    = '0;
        bytes_seen    = '0;
        conts_left    = '0;
        overflow_seen = 1'b0;
      end
      u8o_pkg::ACT_LOAD: begin
        if (pos == '0) begin
          expect_result(make_result(u8o_pkg::KIND_PAIR, '0, '0, 1'b0, overflow_seen, 1'b1));
        end else if (wanted_fifo.size() >= WANTED_DEPTH) begin
          overflow_seen = 1'b1;
        end else begin
          wanted_fifo = {wanted_fifo, pos};
        end
      end
      u8o_pkg::ACT_BYTE: begin
        if (bytes_seen != 32'hFFFF_FFFF) bytes_seen++;
        if (conts_left != '0) begin
          conts_left--;
          if (conts_left == '0) got_pair = close_char(pair);
        end else if (trailing_count(b) == '0) begin
          got_pair = close_char(pair);
        end else begin
          conts_left = trailing_count(b);
        end
        if (got_pair) begin
          pair.last = 1'b1;
          expect_result(pair);
        end
      end
      default: begin
        // finish: a truncated character counts as complete
        if (conts_left != '0) begin
          conts_left = '0;
          got_pair   = close_char(pair);
        end
        if (got_pair) expect_result(pair);
        expect_result(make_result(u8o_pkg::KIND_STATUS, chars_seen, bytes_seen,
                                  wanted_fifo.size() == 0, overflow_seen, 1'b1));
      end
    endcase
  endfunction

  function void add_item(logic [1:0] action, logic [31:0] pos, logic [7:0] b);
    stim_item_t it;
    it.action          = action;
    it.wanted_position = pos;
    it.text_byte       = b;
    stimulus_items = {stimulus_items, it};
  endfunction

  // well-formed character of the given width, cut to nbytes bytes
  function void queue_char(int unsigned width, int unsigned nbytes);
    logic [7:0] lead;
    lead = 8'($urandom);
    case (width)
      1:       lead[7]   = 1'b0;
      2:       lead[7:5] = 3'b110;
      3:       lead[7:4] = 4'b1110;
      default: lead[7:3] = 5'b11110;
    endcase
    add_item(u8o_pkg::ACT_BYTE, $urandom, lead);
    for (int unsigned i = 1; i < nbytes; i++) begin
      add_item(u8o_pkg::ACT_BYTE, $urandom, {2'b10, 6'($urandom)});
    end
  endfunction

  task automatic report_mismatch(input string what, input u8o_pkg::res_t want,
                                 input u8o_pkg::res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected kind=%0d pos=%0d off=%0d all=%0d ovf=%0d last=%0d",
               what, want.kind, want.char_position, want.byte_offset, want.all_resolved,
               want.overflow, want.last);
      $display("                 actual kind=%0d pos=%0d off=%0d all=%0d ovf=%0d last=%0d",
               got.kind, got.char_position, got.byte_offset, got.all_resolved,
               got.overflow, got.last);
    end
  endtask

  // driver: bursts of transfers with random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin : drive_proc
    stim_item_t nxt;
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_ch.ready) begin
        resolve_item(in_ch.action, in_ch.wanted_position, in_ch.text_byte);
        items_accepted++;
      end
      if (!drv_valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          drv_valid <= 1'b0;
        end else if (stimulus_items.size() != 0) begin
          nxt = stimulus_items.pop_front();
          drv_action   <= nxt.action;
          drv_position <= nxt.wanted_position;
          drv_byte     <= nxt.text_byte;
          drv_valid    <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, changing mode when its phase counter runs out
  rx_mode_t    rx_mode    = RX_FREE;
  logic [7:0]  rx_phase   = '0;

  always @(posedge clk) begin
    if (rx_phase == '0) begin
      rx_mode  <= rx_mode_t'($urandom_range(0, 3));
      rx_phase <= 8'($urandom_range(32, 200));
    end else begin
      rx_phase <= rx_phase - 8'd1;
    end
    case (rx_mode)
      RX_FREE:           take_ready <= 1'b1;
      RX_THREE_QUARTERS: take_ready <= (rx_phase[1:0] != 2'd0);
      RX_COIN:           take_ready <= 1'($urandom_range(0, 1));
      default:           take_ready <= (rx_phase[3:0] > 4'd11);
    endcase
  end

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_proc
    u8o_pkg::res_t got;
    u8o_pkg::res_t want;
    if (rst_n && out_ch.valid && take_ready) begin
      got = make_result(out_ch.kind, out_ch.char_position, out_ch.byte_offset,
                        out_ch.all_resolved, out_ch.overflow, out_ch.last);
      if (pending_results.size() == 0) begin
        report_mismatch("no result expected", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.char_position !== want.char_position ||
            got.byte_offset !== want.byte_offset || got.all_resolved !== want.all_resolved ||
            got.overflow !== want.overflow || got.last !== want.last) begin
          report_mismatch("field", want, got);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : main_proc
    int unsigned random_start;
    int unsigned nchars;
    int unsigned width;
    int unsigned nitems;
    int unsigned pick;
    logic [31:0] pos;

    // directed: zero load, every lead width, bad leads, truncated finish
    add_item(u8o_pkg::ACT_LOAD, 32'd0, 8'($urandom));
    add_item(u8o_pkg::ACT_LOAD, 32'd1, 8'($urandom));
    add_item(u8o_pkg::ACT_LOAD, 32'd3, 8'($urandom));
    add_item(u8o_pkg::ACT_LOAD, 32'd4, 8'($urandom));
    add_item(u8o_pkg::ACT_LOAD, 32'd6, 8'($urandom));
    add_item(u8o_pkg::ACT_LOAD, 32'd9, 8'($urandom));
    add_item(u8o_pkg::ACT_BYTE, $urandom, 8'h00);
    add_item(u8o_pkg::ACT_BYTE, $urandom, 8'h7F);
    add_item(u8o_pkg::ACT_BYTE, $urandom, 8'hC3);
    add_item(u8o_pkg::ACT_BYTE, $urandom, 8'hA9);
    add_item(u8o_pkg::ACT_BYTE, $urandom, 8'hE2);
    add_item(u8o_pkg::ACT_BYTE, $urandom, 8'h82);
    add_item(u8o_pkg::ACT_BYTE, $urandom, 8'hAC);
    add_item(u8o_pkg::ACT_BYTE, $urandom, 8'hF0);
    add_item(u8o_pkg::ACT_BYTE, $urandom, 8'h9F);
    add_item(u8o_pkg::ACT_BYTE, $urandom, 8'h98);
    add_item(u8o_pkg::ACT_BYTE, $urandom, 8'h80);
    add_item(u8o_pkg::ACT_BYTE, $urandom, 8'h80);
    add_item(u8o_pkg::ACT_BYTE, $urandom, 8'hFF);
    add_item(u8o_pkg::ACT_BYTE, $urandom, 8'hF8);
    add_item(u8o_pkg::ACT_LOAD, 32'd0, 8'($urandom));
    add_item(u8o_pkg::ACT_BYTE, $urandom, 8'hE0);
    add_item(u8o_pkg::ACT_FINISH, $urandom, 8'($urandom));
    add_item(u8o_pkg::ACT_FINISH, $urandom, 8'($urandom));
    add_item(u8o_pkg::ACT_CLEAR, $urandom, 8'($urandom));

    // fill the wanted queue past its depth, then watch the sticky flag
    for (int unsigned i = 1; i <= WANTED_DEPTH + 2; i++) begin
      add_item(u8o_pkg::ACT_LOAD, i, 8'($urandom));
    end
    add_item(u8o_pkg::ACT_LOAD, 32'hFFFF_FFFF, 8'($urandom));
    add_item(u8o_pkg::ACT_LOAD, 32'd0, 8'($urandom));
    for (int unsigned i = 0; i < 6; i++) begin
      queue_char(1, 1);
    end
    add_item(u8o_pkg::ACT_FINISH, $urandom, 8'($urandom));
    add_item(u8o_pkg::ACT_CLEAR, $urandom, 8'($urandom));
    add_item(u8o_pkg::ACT_LOAD, 32'd0, 8'($urandom));

    // random: mostly well-formed texts with ascending loads, some noise
    random_start = stimulus_items.size();
    while (stimulus_items.size() < random_start + RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) != 0) begin
        nchars = $urandom_range(1, 30);
        if ($urandom_range(0, 6) != 0) add_item(u8o_pkg::ACT_CLEAR, $urandom, 8'($urandom));
        if ($urandom_range(0, 5) == 0) add_item(u8o_pkg::ACT_LOAD, 32'd0, 8'($urandom));
        for (int unsigned p = 1; p <= nchars; p++) begin
          if ($urandom_range(0, 2) == 0) add_item(u8o_pkg::ACT_LOAD, p, 8'($urandom));
        end
        for (int unsigned c = 0; c < nchars; c++) begin
          if ($urandom_range(0, 9) == 0) begin
            // lone continuation or invalid lead
            add_item(u8o_pkg::ACT_BYTE, $urandom,
                     ($urandom_range(0, 1) == 0) ? {2'b10, 6'($urandom)}
                                                 : {5'b11111, 3'($urandom)});
          end else begin
            width = $urandom_range(1, 4);
            if (c == nchars - 1 && width > 1 && $urandom_range(0, 3) == 0) begin
              queue_char(width, $urandom_range(1, width - 1));
            end else begin
              queue_char(width, width);
            end
          end
          if ($urandom_range(0, 40) == 0) add_item(u8o_pkg::ACT_LOAD, 32'd0, 8'($urandom));
        end
        if ($urandom_range(0, 9) != 0) add_item(u8o_pkg::ACT_FINISH, $urandom, 8'($urandom));
      end else begin
        nitems = $urandom_range(4, 24);
        for (int unsigned k = 0; k < nitems; k++) begin
          pick = $urandom_range(0, 2);
          pos  = (pick == 0) ? 32'd0 : (pick == 1) ? $urandom_range(1, 40) : $urandom;
          pick = $urandom_range(0, 9);
          add_item((pick == 0) ? u8o_pkg::ACT_CLEAR : (pick < 4) ? u8o_pkg::ACT_LOAD :
                   (pick < 8) ? u8o_pkg::ACT_BYTE : u8o_pkg::ACT_FINISH, pos,
                   8'($urandom_range(0, 255)));
        end
      end
    end
    items_total = stimulus_items.size();

    // reset, then let the driver and monitor run
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (items_accepted != items_total) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
